// ----- src/yuv420_block_to_rgb_fixed_macros.svh -----
// Assertion macros used by the checker file of the color converter.
`ifndef YUV420_BLOCK_TO_RGB_FIXED_MACROS_SVH
`define YUV420_BLOCK_TO_RGB_FIXED_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define Y2RGB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define Y2RGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/y2rgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package y2rgb_pkg;

   // Arithmetic sizes.
   localparam int FRACTION_BITS = 8;
   localparam int COEF_WIDTH    = 16;
   localparam int SAMPLE_W      = 8;
   localparam int SLOT_W        = 16;
   localparam int OFFSET_W      = 16;
   localparam int TERM_W        = OFFSET_W + 1;
   localparam int PROD_W        = TERM_W + COEF_WIDTH;
   localparam int SUM_W         = PROD_W + 2;
   localparam int CSR_W         = 48;
   localparam int CSR_INDEX_W   = 3;
   localparam int PIXEL_W       = 32;
   localparam int CHAN_W        = 8;

   // Pipeline shape.
   localparam int STAGES   = 4;
   localparam int PIXELS   = 4;
   localparam int CHANNELS = 3;

   // Channel and coefficient slot positions.
   localparam int CH_R   = 0;
   localparam int CH_G   = 1;
   localparam int CH_B   = 2;
   localparam int SLOT_Y = 0;
   localparam int SLOT_U = 1;
   localparam int SLOT_V = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RED    = 3'd0,
      CSR_GREEN  = 3'd1,
      CSR_BLUE   = 3'd2,
      CSR_OFFSET = 3'd3,
      CSR_FORMAT = 3'd4
   } csr_index_type;

   // Output byte orders.
   typedef enum logic [1:0] {
      FMT_ARGB  = 2'd0,
      FMT_BGRA  = 2'd1,
      FMT_RGB24 = 2'd2,
      FMT_BGR24 = 2'd3
   } fmt_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] luma_top_left;
      logic [SAMPLE_W-1:0] luma_top_right;
      logic [SAMPLE_W-1:0] luma_bottom_left;
      logic [SAMPLE_W-1:0] luma_bottom_right;
      logic [SAMPLE_W-1:0] chroma_blue;
      logic [SAMPLE_W-1:0] chroma_red;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_top_left;
      logic [PIXEL_W-1:0] pixel_top_right;
      logic [PIXEL_W-1:0] pixel_bottom_left;
      logic [PIXEL_W-1:0] pixel_bottom_right;
   } rsp_payload_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [CSR_W-1:0] red;
      logic [CSR_W-1:0] green;
      logic [CSR_W-1:0] blue;
      logic [CSR_W-1:0] offsets;
      fmt_type          format;
   } csr_type;

   // Load enables of the four register stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // Coefficient of one slot, sign-extended from its low COEF_WIDTH bits.
   function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [CSR_W-1:0] reg_value,
                                                            input int slot);
      return $signed(reg_value[slot*SLOT_W +: COEF_WIDTH]);
   endfunction

   // Offset of one slot, always a full signed 16-bit value.
   function automatic logic signed [OFFSET_W-1:0] offset_at(input logic [CSR_W-1:0] reg_value,
                                                            input int slot);
      return $signed(reg_value[slot*SLOT_W +: OFFSET_W]);
   endfunction

   // Floor shift of the full sum, then saturation to one byte.
   function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] shifted;
      shifted = sum >>> FRACTION_BITS;
      if (shifted[SUM_W-1]) begin
         return '0;
      end else if (|shifted[SUM_W-1:CHAN_W]) begin
         return '1;
      end else begin
         return shifted[CHAN_W-1:0];
      end
   endfunction

   // Byte 0 of the word is the first byte in memory.
   function automatic logic [PIXEL_W-1:0] pack_pixel(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b,
                                                     input fmt_type format);
      logic [PIXEL_W-1:0] word;
      case (format)
         FMT_ARGB:  word = {b, g, r, 8'h00};
         FMT_RGB24: word = {8'h00, b, g, r};
         default:   word = {8'h00, r, g, b};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// ----- src/yuv420_block_to_rgb_fixed.sv -----
// 4:2:0 block to RGB converter, fixed point.
// Input channel (req_): one item is a 2x2 luma block plus its U and V sample,
// accepted at a rising edge with req_valid high and req_stall low.
// Result channel (rsp_): four packed pixels, taken at a rising edge with
// rsp_valid high and rsp_stall low. rsp_valid never looks at rsp_stall.
// Configuration (csr_): a write with csr_write_enable high stores csr_write_data
// into the register at csr_index; indexes beyond the list are ignored. Write
// only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. An item
// passes the four register stages (offset add, multiply, chroma sum, final sum
// with clamp and packing) before rsp_valid rises.
// A stalled receiver holds the result register; each stage keeps accepting
// as long as a bubble lies ahead of it, so the pipeline fills before
// req_stall rises.
// Reset clears all stage valid bits and sets every configuration register to zero (ARGB).
`timescale 1ns / 1ps
`default_nettype none

module yuv420_block_to_rgb_fixed
   import y2rgb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_payload,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]       csr_write_data
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] ready;
   stage_en_type      stage_en;
   csr_type           csr_ff;
   csr_type           csr_in;

   // Configuration registers.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RED:    csr_in.red     = csr_write_data;
            CSR_GREEN:  csr_in.green   = csr_write_data;
            CSR_BLUE:   csr_in.blue    = csr_write_data;
            CSR_OFFSET: csr_in.offsets = csr_write_data;
            CSR_FORMAT: csr_in.format  = fmt_type'(csr_write_data[1:0]);
            default:    csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{red: '0, green: '0, blue: '0, offsets: '0, format: FMT_ARGB};
      end else begin
         csr_ff <= csr_in;
      end
   end

   // A stage may load when it is empty or the stage after it moves on.
   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int s = STAGES - 2; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = ready[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign stage_en = '{s1: ready[0], s2: ready[1], s3: ready[2], s4: ready[3]};

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[STAGES-1];

   y2rgb_datapath u_datapath (
      .clock       (clock),
      .stage_en    (stage_en),
      .csr         (csr_ff),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- src/y2rgb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module y2rgb_datapath
   import y2rgb_pkg::*;
(
   input  wire logic            clock,
   input  wire stage_en_type    stage_en,
   input  wire csr_type         csr,
   input  wire req_payload_type req_payload,
   output rsp_payload_type      rsp_payload
);

   logic [SAMPLE_W-1:0]     luma [PIXELS];
   logic [CSR_W-1:0]        coef_reg [CHANNELS];

   logic signed [TERM_W-1:0] luma_term_in [PIXELS];
   logic signed [TERM_W-1:0] luma_term_ff [PIXELS];
   logic signed [TERM_W-1:0] u_term_in;
   logic signed [TERM_W-1:0] u_term_ff;
   logic signed [TERM_W-1:0] v_term_in;
   logic signed [TERM_W-1:0] v_term_ff;

   logic signed [PROD_W-1:0] luma_prod_ff [PIXELS][CHANNELS];
   logic signed [PROD_W-1:0] u_prod_ff [CHANNELS];
   logic signed [PROD_W-1:0] v_prod_ff [CHANNELS];

   logic signed [PROD_W-1:0] luma_carry_ff [PIXELS][CHANNELS];
   logic signed [SUM_W-1:0]  chroma_sum_ff [CHANNELS];

   logic signed [SUM_W-1:0]  total [PIXELS][CHANNELS];
   logic [CHAN_W-1:0]        chan [PIXELS][CHANNELS];
   logic [PIXEL_W-1:0]       pixel_word [PIXELS];
   rsp_payload_type          rsp_payload_in;
   rsp_payload_type          rsp_payload_ff;

   assign luma[0] = req_payload.luma_top_left;
   assign luma[1] = req_payload.luma_top_right;
   assign luma[2] = req_payload.luma_bottom_left;
   assign luma[3] = req_payload.luma_bottom_right;

   assign coef_reg[CH_R] = csr.red;
   assign coef_reg[CH_G] = csr.green;
   assign coef_reg[CH_B] = csr.blue;

   // Stage 1: add the signed offsets to the samples.
   always_comb begin
      for (int p = 0; p < PIXELS; p++) begin
         luma_term_in[p] = TERM_W'($signed({1'b0, luma[p]}))
                         + TERM_W'(offset_at(csr.offsets, SLOT_Y));
      end
      u_term_in = TERM_W'($signed({1'b0, req_payload.chroma_blue}))
                + TERM_W'(offset_at(csr.offsets, SLOT_U));
      v_term_in = TERM_W'($signed({1'b0, req_payload.chroma_red}))
                + TERM_W'(offset_at(csr.offsets, SLOT_V));
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         for (int p = 0; p < PIXELS; p++) begin
            luma_term_ff[p] <= luma_term_in[p];
         end
         u_term_ff <= u_term_in;
         v_term_ff <= v_term_in;
      end
   end

   // Stage 2: one multiplier per luma term and channel, two per channel for chroma.
   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         for (int c = 0; c < CHANNELS; c++) begin
            for (int p = 0; p < PIXELS; p++) begin
               luma_prod_ff[p][c] <= PROD_W'(luma_term_ff[p])
                                   * PROD_W'(coef_at(coef_reg[c], SLOT_Y));
            end
            u_prod_ff[c] <= PROD_W'(u_term_ff) * PROD_W'(coef_at(coef_reg[c], SLOT_U));
            v_prod_ff[c] <= PROD_W'(v_term_ff) * PROD_W'(coef_at(coef_reg[c], SLOT_V));
         end
      end
   end

   // Stage 3: the chroma part of each channel, shared by all four pixels.
   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         for (int c = 0; c < CHANNELS; c++) begin
            chroma_sum_ff[c] <= SUM_W'(u_prod_ff[c]) + SUM_W'(v_prod_ff[c]);
            for (int p = 0; p < PIXELS; p++) begin
               luma_carry_ff[p][c] <= luma_prod_ff[p][c];
            end
         end
      end
   end

   // Stage 4: final sum, floor shift, clamp and byte packing.
   always_comb begin
      for (int p = 0; p < PIXELS; p++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            total[p][c] = SUM_W'(luma_carry_ff[p][c]) + chroma_sum_ff[c];
            chan[p][c]  = clamp_channel(total[p][c]);
         end
         pixel_word[p] = pack_pixel(chan[p][CH_R], chan[p][CH_G], chan[p][CH_B], csr.format);
      end
      rsp_payload_in.pixel_top_left     = pixel_word[0];
      rsp_payload_in.pixel_top_right    = pixel_word[1];
      rsp_payload_in.pixel_bottom_left  = pixel_word[2];
      rsp_payload_in.pixel_bottom_right = pixel_word[3];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ----- src/y2rgb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "yuv420_block_to_rgb_fixed_macros.svh"

module y2rgb_checker
   import y2rgb_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   // A result held back by the receiver stays put.
   `Y2RGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                      rsp_valid && $stable(rsp_payload), "held result changed")

   // Reset empties the pipeline.
   `Y2RGB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid,
                      "result valid after reset")

   // With a free receiver the block never pushes back.
   `Y2RGB_ASSERT_IMPLY(a_no_stall, clock, reset, !rsp_stall, !req_stall,
                       "input stalled while output free")

   // An item accepted while the receiver stays free reaches the output with rsp_valid high.
   `Y2RGB_ASSERT_NEXT(a_latency, clock, reset,
                      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall
                         ##1 !rsp_stall ##1 !rsp_stall,
                      rsp_valid, "item did not arrive after four cycles")

endmodule

bind yuv420_block_to_rgb_fixed y2rgb_checker u_checker (.*);

`default_nettype wire
